>>> rtl/core/csrmv_pkg.sv
// Package for the CSR sparse matrix-vector core: sizes, codes, request/result types.
package csrmv_pkg;

    localparam int ROWS       = 64;
    localparam int NONZEROS   = 1024;
    localparam int VECTOR_LEN = 64;
    localparam int DATA_WIDTH = 32;

    localparam int RP_DEPTH = ROWS + 1;
    localparam int RP_AW    = (RP_DEPTH > 1) ? $clog2(RP_DEPTH) : 1;
    localparam int NZ_AW    = (NONZEROS > 1) ? $clog2(NONZEROS) : 1;
    localparam int VEC_AW   = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
    localparam int PTR_W    = $clog2(NONZEROS + 1);

    typedef enum logic [1:0] {
        OP_ROW_PTR = 2'd0,
        OP_NONZERO = 2'd1,
        OP_VECTOR  = 2'd2,
        OP_COMPUTE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_END,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t                op;
        logic [9:0]         slot;
        logic [5:0]         column;
        logic signed [31:0] value;
        logic [10:0]        pointer;
    } in_t;

    typedef struct packed {
        logic [5:0]         row;
        logic signed [31:0] product;
    } out_t;

    typedef struct packed {
        logic [5:0]            column;
        logic [DATA_WIDTH-1:0] value;
    } nz_word_t;

    typedef struct packed {
        logic clear;
        logic nz_valid;
        logic col_ok;
    } mac_ctl_t;

    function automatic logic [PTR_W-1:0] clamp_ptr(logic [10:0] p);
        if (32'(p) > NONZEROS) begin
            return PTR_W'(NONZEROS);
        end
        return PTR_W'(p);
    endfunction

endpackage

>>> rtl/core/csrmv_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module csrmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/csrmv_mac.sv
// Multiply-accumulate datapath: operand stage, product register, accumulator.
module csrmv_mac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  csrmv_pkg::mac_ctl_t                 ctl,
    input  logic [csrmv_pkg::DATA_WIDTH-1:0]    nz_value,
    input  logic [csrmv_pkg::DATA_WIDTH-1:0]    vec_value,
    output logic [csrmv_pkg::DATA_WIDTH-1:0]    acc,
    output logic                                busy
);

    localparam int DW = csrmv_pkg::DATA_WIDTH;

    logic          op_valid_reg;
    logic          op_ok_reg;
    logic [DW-1:0] op_value_reg;
    logic          prod_valid_reg;
    logic [DW-1:0] prod_reg;
    logic [DW-1:0] acc_reg;
    logic [DW-1:0] acc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            op_valid_reg   <= ctl.nz_valid;
            prod_valid_reg <= op_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        op_value_reg <= nz_value;
        op_ok_reg    <= ctl.col_ok;
        prod_reg     <= op_ok_reg ? DW'(op_value_reg * vec_value) : '0;
        acc_reg      <= acc_next;
    end

    always_comb begin
        acc_next = acc_reg;
        if (ctl.clear) begin
            acc_next = '0;
        end else if (prod_valid_reg) begin
            acc_next = acc_reg + prod_reg;
        end
    end

    assign acc  = acc_reg;
    assign busy = op_valid_reg | prod_valid_reg;

endmodule

>>> rtl/core/csr_sparse_matvec_core.sv
// CSR sparse matrix-vector core: table loads, row walk control, result register.
//
//  channel  | ports                      | carries
//  ---------+----------------------------+---------------------------------
//  request  | s_valid s_ready s_data     | op, slot, column, value, pointer
//  result   | m_valid m_ready m_data     | row, product
//
// A load request is written to its table when taken. A compute request makes
// two row-pointer reads, then one nonzero read per cycle for each nonzero of
// the row (none for an empty row), drains the four-deep read/multiply/accumulate
// pipeline and waits to see it empty before the result is registered.
// Reset clears control only; table contents are undefined until loaded.
// A finished row waits in the result register; new requests are taken while it
// waits, and only a second finished row stalls on m_ready.
module csr_sparse_matvec_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  csrmv_pkg::in_t     s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output csrmv_pkg::out_t    m_data
);

    localparam int DW     = csrmv_pkg::DATA_WIDTH;
    localparam int RP_AW  = csrmv_pkg::RP_AW;
    localparam int NZ_AW  = csrmv_pkg::NZ_AW;
    localparam int VEC_AW = csrmv_pkg::VEC_AW;
    localparam int PTR_W  = csrmv_pkg::PTR_W;
    localparam int NZW    = $bits(csrmv_pkg::nz_word_t);

    csrmv_pkg::state_t state_reg, state_next;
    logic [RP_AW-1:0]  row_reg, row_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [PTR_W-1:0]  end_reg, end_next;
    logic              nz_valid_reg;
    logic              m_valid_reg, m_valid_next;
    csrmv_pkg::out_t   m_data_reg, m_data_next;

    logic              s_acc;
    logic              compute_ok;
    logic              issue;
    logic              rp_we, rp_re;
    logic [RP_AW-1:0]  rp_raddr;
    logic [10:0]       rp_rdata;
    logic              nz_we, nz_re;
    csrmv_pkg::nz_word_t nz_wdata, nz_rdata;
    logic [NZW-1:0]    nz_rdata_raw;
    logic              vec_we;
    logic [DW-1:0]     vec_rdata;
    logic [DW-1:0]     data_ext;
    csrmv_pkg::mac_ctl_t mac_ctl;
    logic [DW-1:0]     acc;
    logic              mac_busy;

    assign s_ready    = (state_reg == csrmv_pkg::ST_IDLE);
    assign s_acc      = s_valid && s_ready;
    assign compute_ok = (s_data.op == csrmv_pkg::OP_COMPUTE)
                        && (32'(s_data.slot) < csrmv_pkg::ROWS);
    assign data_ext   = DW'(s_data.value);

    assign rp_we  = s_acc && (s_data.op == csrmv_pkg::OP_ROW_PTR)
                    && (32'(s_data.slot) < csrmv_pkg::RP_DEPTH);
    assign nz_we  = s_acc && (s_data.op == csrmv_pkg::OP_NONZERO)
                    && (32'(s_data.slot) < csrmv_pkg::NONZEROS);
    assign vec_we = s_acc && (s_data.op == csrmv_pkg::OP_VECTOR)
                    && (32'(s_data.slot) < csrmv_pkg::VECTOR_LEN);

    assign nz_wdata.column = s_data.column;
    assign nz_wdata.value  = data_ext;
    assign nz_rdata        = csrmv_pkg::nz_word_t'(nz_rdata_raw);

    // writes happen only in idle, so no read in flight can hit them
    assign rp_re    = (s_acc && compute_ok) || (state_reg == csrmv_pkg::ST_START);
    assign rp_raddr = (state_reg == csrmv_pkg::ST_IDLE) ? RP_AW'(s_data.slot)
                                                        : row_reg + 1'b1;

    assign issue = (state_reg == csrmv_pkg::ST_WALK) && (ptr_reg < end_reg);
    assign nz_re = issue;

    assign mac_ctl.clear    = (state_reg == csrmv_pkg::ST_END);
    assign mac_ctl.nz_valid = nz_valid_reg;
    assign mac_ctl.col_ok   = 32'(nz_rdata.column) < csrmv_pkg::VECTOR_LEN;

    csrmv_ram #(.WIDTH(11), .DEPTH(csrmv_pkg::RP_DEPTH)) u_rowptr (
        .aclk  (aclk),
        .we    (rp_we),
        .waddr (RP_AW'(s_data.slot)),
        .wdata (s_data.pointer),
        .re    (rp_re),
        .raddr (rp_raddr),
        .rdata (rp_rdata)
    );

    csrmv_ram #(.WIDTH(NZW), .DEPTH(csrmv_pkg::NONZEROS)) u_nonzero (
        .aclk  (aclk),
        .we    (nz_we),
        .waddr (NZ_AW'(s_data.slot)),
        .wdata (nz_wdata),
        .re    (nz_re),
        .raddr (NZ_AW'(ptr_reg)),
        .rdata (nz_rdata_raw)
    );

    csrmv_ram #(.WIDTH(DW), .DEPTH(csrmv_pkg::VECTOR_LEN)) u_vector (
        .aclk  (aclk),
        .we    (vec_we),
        .waddr (VEC_AW'(s_data.slot)),
        .wdata (data_ext),
        .re    (nz_valid_reg),
        .raddr (VEC_AW'(nz_rdata.column)),
        .rdata (vec_rdata)
    );

    csrmv_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (mac_ctl),
        .nz_value  (nz_rdata.value),
        .vec_value (vec_rdata),
        .acc       (acc),
        .busy      (mac_busy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= csrmv_pkg::ST_IDLE;
            nz_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            nz_valid_reg <= issue;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg    <= row_next;
        ptr_reg    <= ptr_next;
        end_reg    <= end_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        row_next     = row_reg;
        ptr_next     = ptr_reg;
        end_next     = end_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            csrmv_pkg::ST_IDLE: begin
                if (s_acc && compute_ok) begin
                    row_next   = RP_AW'(s_data.slot);
                    state_next = csrmv_pkg::ST_START;
                end
            end
            csrmv_pkg::ST_START: begin
                ptr_next   = csrmv_pkg::clamp_ptr(rp_rdata);
                state_next = csrmv_pkg::ST_END;
            end
            csrmv_pkg::ST_END: begin
                end_next   = csrmv_pkg::clamp_ptr(rp_rdata);
                state_next = csrmv_pkg::ST_WALK;
            end
            csrmv_pkg::ST_WALK: begin
                if (issue) begin
                    ptr_next = ptr_reg + 1'b1;
                end else if (!nz_valid_reg && !mac_busy) begin
                    state_next = csrmv_pkg::ST_DONE;
                end
            end
            csrmv_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.row     = 6'(row_reg);
                    m_data_next.product = 32'($unsigned(acc));
                    m_valid_next        = 1'b1;
                    state_next          = csrmv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = csrmv_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!nz_valid_reg && !mac_busy))
        else $error("request taken while row pipeline busy");

    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |=> (ptr_reg <= end_reg))
        else $error("nonzero pointer ran past row end");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg || m_ready) && !(state_reg == csrmv_pkg::ST_DONE) |=> !m_valid_reg)
        else $error("result raised outside done state");

    a_read_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        nz_valid_reg |-> ($past(state_reg) == csrmv_pkg::ST_WALK))
        else $error("nonzero read outside row walk");

endmodule
